@@ hdl/cdvt_pkg.sv @@
// Shared types and constants for the CAN device value table.
package cdvt_pkg;

	localparam int IDENT_W         = 29;
	localparam int STD_IDENT_W     = 11;
	localparam int PAYLOAD_W       = 64;
	localparam int WHOLE_W         = 24;
	localparam int FRAC_W          = 8;
	localparam int SLOT_W          = 4;
	localparam int COUNT_OUT_W     = 5;
	localparam int MAX_DEVICES_DEF = 16;

	typedef enum logic [1:0] {
		FUNC_FRAME  = 2'd0,
		FUNC_ADD    = 2'd1,
		FUNC_REMOVE = 2'd2,
		FUNC_READ   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_IGNORED = 3'd1,
		ST_NOT_REG = 3'd2,
		ST_DUP     = 3'd3,
		ST_FULL    = 3'd4,
		ST_EMPTY   = 3'd5
	} status_t;

	typedef struct packed {
		func_t                func;
		logic [IDENT_W-1:0]   frame_ident;
		logic                 extended_flag;
		logic                 remote_flag;
		logic                 error_flag;
		logic [PAYLOAD_W-1:0] payload;
		logic [IDENT_W-1:0]   device_ident;
		logic [SLOT_W-1:0]    slot;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [IDENT_W-1:0]     entry_ident;
		logic [WHOLE_W-1:0]     speed_whole;
		logic [FRAC_W-1:0]      speed_hundredths;
		logic [WHOLE_W-1:0]     flow_whole;
		logic [FRAC_W-1:0]      flow_hundredths;
		logic [COUNT_OUT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [IDENT_W-1:0]   ident;
		logic [PAYLOAD_W-1:0] values;
	} entry_t;

endpackage

@@ hdl/cdvt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module cdvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ hdl/can_device_value_table_unit.sv @@
// Top level: CAN identifier table with per-device speed and flow values.
// One item at a time. Received frames, add and remove scan the table one entry per
// cycle through the RAM read port; ignored frames skip the scan. A remove of any entry
// but the last then copies the last entry into the freed slot; read slot does not scan.
// The next item is taken once the result sits in the output register.
// Reset clears the device count and control; the RAM keeps no reset and is not swept.
module can_device_value_table_unit #(
	parameter int MAX_DEVICES = cdvt_pkg::MAX_DEVICES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  cdvt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cdvt_pkg::rsp_t rsp
);

	import cdvt_pkg::*;

	localparam int IDX_W      = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int CNT_W      = $clog2(MAX_DEVICES + 1);
	localparam int SLOT_EXT_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
	localparam int ENTRY_W    = $bits(entry_t);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DEVICES);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_SCAN      = 7'b0000010,
		S_MOVE_RD   = 7'b0000100,
		S_MOVE_WR   = 7'b0001000,
		S_SLOT_RD   = 7'b0010000,
		S_SLOT_WAIT = 7'b0100000,
		S_DONE      = 7'b1000000
	} state_t;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
	logic                 pend_s1, pend_d;
	logic [CNT_W-1:0]     cmp_idx_s1, cmp_idx_d;
	logic                 rsp_valid_q, rsp_valid_d;
	rsp_t                 rsp_q, rsp_d;
	func_t                func_q, func_d;
	logic [IDENT_W-1:0]   key_q, key_d;
	logic [PAYLOAD_W-1:0] payload_q, payload_d;
	logic [SLOT_W-1:0]    slot_q, slot_d;
	logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
	rsp_t                 res_q, res_d;

	logic                 mem_rd_en;
	logic [IDX_W-1:0]     mem_rd_addr;
	logic                 mem_wr_en;
	logic [IDX_W-1:0]     mem_wr_addr;
	logic [ENTRY_W-1:0]   mem_wr_data;
	logic [ENTRY_W-1:0]   mem_rd_data;
	entry_t               rd_entry;

	logic [IDENT_W-1:0]   req_fid;
	logic [IDENT_W-1:0]   req_key;
	logic                 req_ignored;
	logic                 slot_ok;
	logic                 key_hit;
	logic                 miss;
	logic [CNT_W-1:0]     last_idx;
	logic [SLOT_EXT_W-1:0] slot_q_ext;

	function automatic rsp_t with_values(rsp_t r, logic [PAYLOAD_W-1:0] v);
		rsp_t o;
		o                  = r;
		o.speed_whole      = v[63:40];
		o.speed_hundredths = v[39:32];
		o.flow_whole       = v[31:8];
		o.flow_hundredths  = v[7:0];
		return o;
	endfunction

	cdvt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_DEVICES)
	) u_table (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	assign rd_entry    = entry_t'(mem_rd_data);
	assign req_fid     = req.extended_flag ? req.frame_ident
	                                       : IDENT_W'(req.frame_ident[STD_IDENT_W-1:0]);
	assign req_key     = (req.func == FUNC_FRAME) ? req_fid : req.device_ident;
	assign req_ignored = req.error_flag || req.remote_flag;
	assign slot_ok     = SLOT_EXT_W'(req.slot) < SLOT_EXT_W'(count_q);
	assign key_hit     = pend_s1 && (rd_entry.ident == key_q);
	assign miss        = !pend_s1 && (rd_idx_q >= count_q);
	assign last_idx    = count_q - CNT_ONE;
	assign slot_q_ext  = SLOT_EXT_W'(slot_q);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		rd_idx_d    = rd_idx_q;
		pend_d      = 1'b0;
		cmp_idx_d   = rd_idx_q;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		rsp_d       = rsp_q;
		func_d      = func_q;
		key_d       = key_q;
		payload_d   = payload_q;
		slot_d      = slot_q;
		hit_idx_d   = hit_idx_q;
		res_d       = res_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = rd_idx_q[IDX_W-1:0];
		mem_wr_en   = 1'b0;
		mem_wr_addr = cmp_idx_s1[IDX_W-1:0];
		mem_wr_data = {key_q, payload_q};

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					func_d   = req.func;
					key_d    = req_key;
					payload_d = req.payload;
					slot_d   = req.slot;
					rd_idx_d = '0;
					res_d    = '0;
					case (req.func)
						FUNC_READ: begin
							if (slot_ok) begin
								state_d = S_SLOT_RD;
							end else begin
								res_d.status = ST_EMPTY;
								state_d      = S_DONE;
							end
						end
						FUNC_FRAME: begin
							if (req_ignored) begin
								res_d.status = ST_IGNORED;
								state_d      = S_DONE;
							end else begin
								state_d = S_SCAN;
							end
						end
						default: begin
							state_d = S_SCAN;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (key_hit || miss) begin
					res_d.entry_ident = key_q;
					state_d           = S_DONE;
					case (func_q)
						FUNC_FRAME: begin
							if (key_hit) begin
								mem_wr_en    = 1'b1;
								res_d.status = ST_OK;
								res_d        = with_values(res_d, payload_q);
							end else begin
								res_d.status = ST_NOT_REG;
							end
						end
						FUNC_ADD: begin
							if (key_hit) begin
								res_d.status = ST_DUP;
							end else if (count_q == CNT_MAX) begin
								res_d.status = ST_FULL;
							end else begin
								mem_wr_en    = 1'b1;
								mem_wr_addr  = count_q[IDX_W-1:0];
								mem_wr_data  = {key_q, {PAYLOAD_W{1'b0}}};
								count_d      = count_q + CNT_ONE;
								res_d.status = ST_OK;
							end
						end
						FUNC_REMOVE: begin
							if (key_hit) begin
								res_d.status = ST_OK;
								res_d        = with_values(res_d, rd_entry.values);
								count_d      = last_idx;
								hit_idx_d    = cmp_idx_s1[IDX_W-1:0];
								if (cmp_idx_s1 != last_idx) begin
									state_d = S_MOVE_RD;
								end
							end else begin
								res_d.status = ST_NOT_REG;
							end
						end
						default: begin
							res_d.status = ST_NOT_REG;
						end
					endcase
				end else begin
					mem_rd_en = (rd_idx_q < count_q);
					pend_d    = mem_rd_en;
					if (mem_rd_en) begin
						rd_idx_d = rd_idx_q + CNT_ONE;
					end
				end
			end
			S_MOVE_RD: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = count_q[IDX_W-1:0];
				state_d     = S_MOVE_WR;
			end
			S_MOVE_WR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = hit_idx_q;
				mem_wr_data = mem_rd_data;
				state_d     = S_DONE;
			end
			S_SLOT_RD: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = slot_q_ext[IDX_W-1:0];
				state_d     = S_SLOT_WAIT;
			end
			S_SLOT_WAIT: begin
				res_d.status      = ST_OK;
				res_d.entry_ident = rd_entry.ident;
				res_d             = with_values(res_d, rd_entry.values);
				state_d           = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_d             = res_q;
					rsp_d.entry_count = COUNT_OUT_W'(count_q);
					rsp_valid_d       = 1'b1;
					state_d           = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rd_idx_q    <= rd_idx_d;
			pend_s1     <= pend_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= cmp_idx_d;
		rsp_q      <= rsp_d;
		func_q     <= func_d;
		key_q      <= key_d;
		payload_q  <= payload_d;
		slot_q     <= slot_d;
		hit_idx_q  <= hit_idx_d;
		res_q      <= res_d;
	end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the CAN device value table, with queue-fed driver and clocked monitor.
module tb_top;
	import cdvt_pkg::*;

	localparam int MAX_DEV     = MAX_DEVICES_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	req_t queued_reqs[$];
	rsp_t awaited_rsps[$];
	logic [IDENT_W-1:0] gen_ids[$];

	logic [IDENT_W-1:0] tbl_ident[MAX_DEV];
	logic [WHOLE_W-1:0] tbl_speed_whole[MAX_DEV];
	logic [FRAC_W-1:0]  tbl_speed_frac[MAX_DEV];
	logic [WHOLE_W-1:0] tbl_flow_whole[MAX_DEV];
	logic [FRAC_W-1:0]  tbl_flow_frac[MAX_DEV];
	int tbl_count = 0;

	bit idle_on = 1'b1;
	bit req_fire = 1'b0;
	int req_gap = 0;
	int rsp_gap = 0;
	int mismatch_cnt = 0;
	int quiet_cycles = 0;

	can_device_value_table_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int table_pos(logic [IDENT_W-1:0] id);
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_ident[i] == id) return i;
		end
		return -1;
	endfunction

	function automatic rsp_t apply_to_table(req_t r);
		rsp_t e;
		int k;
		int last;
		logic [IDENT_W-1:0] id;
		e = '0;
		case (r.func)
			FUNC_FRAME: begin
				if (r.error_flag || r.remote_flag) begin
					e.status = ST_IGNORED;
				end else begin
					id = r.extended_flag ? r.frame_ident :
						{{(IDENT_W-STD_IDENT_W){1'b0}}, r.frame_ident[STD_IDENT_W-1:0]};
					k = table_pos(id);
					e.entry_ident = id;
					if (k < 0) begin
						e.status = ST_NOT_REG;
					end else begin
						tbl_speed_whole[k] = r.payload[63:40];
						tbl_speed_frac[k]  = r.payload[39:32];
						tbl_flow_whole[k]  = r.payload[31:8];
						tbl_flow_frac[k]   = r.payload[7:0];
						e.status           = ST_OK;
						e.speed_whole      = tbl_speed_whole[k];
						e.speed_hundredths = tbl_speed_frac[k];
						e.flow_whole       = tbl_flow_whole[k];
						e.flow_hundredths  = tbl_flow_frac[k];
					end
				end
			end
			FUNC_ADD: begin
				e.entry_ident = r.device_ident;
				if (table_pos(r.device_ident) >= 0) begin
					e.status = ST_DUP;
				end else if (tbl_count >= MAX_DEV) begin
					e.status = ST_FULL;
				end else begin
					tbl_ident[tbl_count]       = r.device_ident;
					tbl_speed_whole[tbl_count] = '0;
					tbl_speed_frac[tbl_count]  = '0;
					tbl_flow_whole[tbl_count]  = '0;
					tbl_flow_frac[tbl_count]   = '0;
					tbl_count++;
					e.status = ST_OK;
				end
			end
			FUNC_REMOVE: begin
				e.entry_ident = r.device_ident;
				k = table_pos(r.device_ident);
				if (k < 0) begin
					e.status = ST_NOT_REG;
				end else begin
					e.status           = ST_OK;
					e.speed_whole      = tbl_speed_whole[k];
					e.speed_hundredths = tbl_speed_frac[k];
					e.flow_whole       = tbl_flow_whole[k];
					e.flow_hundredths  = tbl_flow_frac[k];
					last = tbl_count - 1;
					tbl_ident[k]       = tbl_ident[last];
					tbl_speed_whole[k] = tbl_speed_whole[last];
					tbl_speed_frac[k]  = tbl_speed_frac[last];
					tbl_flow_whole[k]  = tbl_flow_whole[last];
					tbl_flow_frac[k]   = tbl_flow_frac[last];
					tbl_count          = last;
				end
			end
			default: begin
				k = int'(r.slot);
				if (k >= tbl_count) begin
					e.status = ST_EMPTY;
				end else begin
					e.status           = ST_OK;
					e.entry_ident      = tbl_ident[k];
					e.speed_whole      = tbl_speed_whole[k];
					e.speed_hundredths = tbl_speed_frac[k];
					e.flow_whole       = tbl_flow_whole[k];
					e.flow_hundredths  = tbl_flow_frac[k];
				end
			end
		endcase
		e.entry_count = COUNT_OUT_W'(tbl_count);
		return e;
	endfunction

	function automatic string rsp_text(rsp_t x);
		return $sformatf("st=%0d id=%h spd=%h.%h flow=%h.%h n=%0d", x.status, x.entry_ident,
			x.speed_whole, x.speed_hundredths, x.flow_whole, x.flow_hundredths, x.entry_count);
	endfunction

	// driver: hold a stalled beat, else idle or present the next one
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_fire) begin
			end else if (req_gap > 0) begin
				req_gap <= req_gap - 1;
				req_valid <= 1'b0;
			end else if (queued_reqs.size() > 0) begin
				req <= queued_reqs.pop_front();
				req_valid <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 11);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_gap > 0) begin
				rsp_gap <= rsp_gap - 1;
				rsp_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				rsp_gap <= $urandom_range(0, 10);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// monitor: check the result beat first, then predict for the accepted request beat
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			req_fire <= req_valid && !req_stall;
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsps.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) $display("unexpected result beat: %s", rsp_text(rsp));
				end else begin
					want = awaited_rsps.pop_front();
					if (rsp.status !== want.status || rsp.entry_ident !== want.entry_ident ||
						rsp.speed_whole !== want.speed_whole ||
						rsp.speed_hundredths !== want.speed_hundredths ||
						rsp.flow_whole !== want.flow_whole ||
						rsp.flow_hundredths !== want.flow_hundredths ||
						rsp.entry_count !== want.entry_count) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("mismatch at %0t: expected %s", $realtime, rsp_text(want));
							$display("               got      %s", rsp_text(rsp));
						end
					end
				end
			end
			if (req_valid && !req_stall) awaited_rsps.push_back(apply_to_table(req));
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int shadow_pos(logic [IDENT_W-1:0] id);
		foreach (gen_ids[i]) begin
			if (gen_ids[i] == id) return i;
		end
		return -1;
	endfunction

	function automatic logic [IDENT_W-1:0] pick_ident();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			2: return IDENT_W'(11'h7FF);
			3: return IDENT_W'(12'h800);
			4, 5, 6, 7, 8, 9, 10, 11: return IDENT_W'($urandom_range(0, 2047));
			default: return IDENT_W'($urandom);
		endcase
	endfunction

	function automatic req_t fresh_req(func_t f);
		logic [159:0] raw;
		req_t r;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(req_t)-1:0];
		r.func = f;
		return r;
	endfunction

	task automatic push_item(req_t r);
		int k;
		k = shadow_pos(r.device_ident);
		if (r.func == FUNC_ADD && k < 0 && gen_ids.size() < MAX_DEV) begin
			gen_ids.push_back(r.device_ident);
		end else if (r.func == FUNC_REMOVE && k >= 0) begin
			gen_ids[k] = gen_ids[$];
			gen_ids.pop_back();
		end
		queued_reqs.push_back(r);
	endtask

	task automatic push_op(func_t f, logic [IDENT_W-1:0] id, logic [SLOT_W-1:0] s);
		req_t r;
		r = fresh_req(f);
		r.device_ident = id;
		r.slot = s;
		push_item(r);
	endtask

	task automatic push_frame(logic [IDENT_W-1:0] id, bit ext, bit rmt, bit err,
		logic [PAYLOAD_W-1:0] pl);
		req_t r;
		r = fresh_req(FUNC_FRAME);
		r.frame_ident = id;
		r.extended_flag = ext;
		r.remote_flag = rmt;
		r.error_flag = err;
		r.payload = pl;
		push_item(r);
	endtask

	task automatic rand_item(int wf, int wa, int wr, int wd);
		req_t r;
		int pick;
		logic [IDENT_W-1:0] id;
		pick = $urandom_range(0, wf + wa + wr + wd - 1);
		if (pick < wf) begin
			r = fresh_req(FUNC_FRAME);
			if ($urandom_range(0, 9) < 8) begin
				r.error_flag = 1'b0;
				r.remote_flag = 1'b0;
			end
			case ($urandom_range(0, 9))
				0: r.payload = '0;
				1: r.payload = '1;
				default: ;
			endcase
			if (gen_ids.size() > 0 && $urandom_range(0, 3) != 0) begin
				id = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
				if (id[IDENT_W-1:STD_IDENT_W] == '0 && $urandom_range(0, 1)) begin
					r.extended_flag = 1'b0;
					r.frame_ident[STD_IDENT_W-1:0] = id[STD_IDENT_W-1:0];
				end else begin
					r.extended_flag = 1'b1;
					r.frame_ident = id;
				end
			end
		end else if (pick < wf + wa) begin
			r = fresh_req(FUNC_ADD);
			if (gen_ids.size() > 0 && $urandom_range(0, 4) == 0)
				r.device_ident = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
			else
				r.device_ident = pick_ident();
		end else if (pick < wf + wa + wr) begin
			r = fresh_req(FUNC_REMOVE);
			if (gen_ids.size() > 0 && $urandom_range(0, 3) != 0)
				r.device_ident = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
			else
				r.device_ident = pick_ident();
		end else begin
			r = fresh_req(FUNC_READ);
			if (gen_ids.size() > 0 && $urandom_range(0, 9) < 7)
				r.slot = SLOT_W'($urandom_range(0, gen_ids.size() - 1));
		end
		push_item(r);
	endtask

	task automatic wait_drained();
		while (queued_reqs.size() != 0 || req_valid || awaited_rsps.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int n;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_op(FUNC_READ, '0, '0);
		push_op(FUNC_REMOVE, '1, '0);
		push_frame('1, 1'b1, 1'b0, 1'b0, '1);
		push_op(FUNC_ADD, '1, '0);
		push_op(FUNC_ADD, '1, '0);
		push_op(FUNC_ADD, '0, '0);
		push_op(FUNC_ADD, IDENT_W'(11'h7FF), '0);
		push_frame('1, 1'b1, 1'b0, 1'b0, '1);
		push_frame(29'h1FFFF7FF, 1'b0, 1'b0, 1'b0, 64'h0123456789ABCDEF);
		push_frame('0, 1'b0, 1'b0, 1'b0, '0);
		push_frame('1, 1'b1, 1'b0, 1'b1, '1);
		push_frame('1, 1'b1, 1'b1, 1'b0, '1);
		push_frame('1, 1'b1, 1'b1, 1'b1, '1);
		push_frame(IDENT_W'(12'h800), 1'b1, 1'b0, 1'b0, '1);
		push_op(FUNC_READ, '0, 4'd1);
		push_op(FUNC_READ, '0, '1);
		push_op(FUNC_REMOVE, '0, '0);
		push_op(FUNC_READ, '0, 4'd1);
		push_op(FUNC_REMOVE, '0, '0);
		push_op(FUNC_READ, '0, 4'd2);
		wait_drained();

		// fill to capacity, probe full and duplicate handling, then update, read and remove entries
		while (gen_ids.size() < MAX_DEV) push_op(FUNC_ADD, pick_ident(), '0);
		push_op(FUNC_ADD, '1, '0);
		for (n = 0; n < 2; n++) begin
			push_op(FUNC_ADD, IDENT_W'($urandom) | IDENT_W'(1 << 28), '0);
		end
		for (n = 0; n < MAX_DEV; n++) begin
			push_frame(gen_ids[n], 1'b1, 1'b0, 1'b0, {$urandom, $urandom});
		end
		push_op(FUNC_READ, '0, '1);
		push_op(FUNC_REMOVE, gen_ids[0], '0);
		push_op(FUNC_READ, '0, '0);
		push_op(FUNC_REMOVE, gen_ids[gen_ids.size() - 1], '0);
		push_op(FUNC_READ, '0, 4'd14);
		wait_drained();

		for (int c = 0; c < 5; c++) begin
			if (c == 4) idle_on = 1'b0;
			for (n = 0; n < ((c == 4) ? 300 : 400); n++) begin
				case (c)
					0: rand_item(4, 4, 1, 1);
					1: rand_item(6, 2, 2, 1);
					2: rand_item(3, 2, 3, 2);
					3: rand_item(5, 3, 2, 2);
					default: rand_item(5, 2, 2, 2);
				endcase
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && awaited_rsps.size() == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
